/* rtl/srq_pkg.sv */
// Package: shared types, constants and codes for the sound request queue allocator.
package srq_pkg;

  localparam int unsigned QueueDepthDefault = 64;
  localparam int unsigned VoiceCountDefault = 13;
  localparam logic [8:0]  IdLimitReset      = 9'h070;
  localparam logic [7:0]  CenterPan         = 8'h80;
  localparam logic [7:0]  VolumeMax         = 8'hFF;

  typedef enum logic [1:0] {
    OpEnqueue = 2'd0,
    OpTick    = 2'd1,
    OpDone    = 2'd2,
    OpFlush   = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    CmdNone  = 2'd0,
    CmdStart = 2'd1,
    CmdStop  = 2'd2
  } cmd_e;

  typedef enum logic [1:0] {
    StOk      = 2'd0,
    StFull    = 2'd1,
    StDropped = 2'd2,
    StPending = 2'd3
  } status_e;

  typedef struct packed {
    logic [1:0]        operation;
    logic [7:0]        sound_id;
    logic signed [15:0] req_volume;
    logic [7:0]        req_priority;
    logic [3:0]        done_slot;
  } req_t;

  typedef struct packed {
    logic [1:0] command;
    logic [3:0] voice_slot;
    logic [7:0] out_sound_id;
    logic [7:0] out_volume;
    logic [7:0] out_pan;
    logic [7:0] out_priority;
    logic [1:0] status;
  } rsp_t;

  // Ring entry: id, clamped volume, priority
  typedef struct packed {
    logic [7:0] id;
    logic [7:0] vol;
    logic [7:0] pri;
  } ring_entry_t;

  typedef enum logic [3:0] {
    SIdle,
    SRingRd,
    SRingLoad,
    STailRd,
    STailChk,
    SWalkRd,
    SWalkChk,
    SLinkA,
    SLinkB,
    SUnlinkRd,
    SUnlinkA,
    SUnlinkB,
    SOut
  } state_e;

endpackage

/* rtl/sound_request_queue_voice_allocator.sv */
// Top level: request ring and voice allocator with memory-held linked voice list.
// Enqueue and flush answer straight from idle; a tick walks the sorted voice list, reading
// one voice entry per walk step; voice done reads the entry, then relinks its neighbours.
// Throughput: one transaction at a time; the result register frees the input side once taken.
// Reset: asynchronous, clears pointers, pending request and list head/tail, sets the free count
// to VOICE_COUNT; the free stack is reset to slots 0..VOICE_COUNT-1 in flip-flops; memories are not cleared.
module sound_request_queue_voice_allocator
  import srq_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = QueueDepthDefault,
  parameter int unsigned VOICE_COUNT = VoiceCountDefault
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic [8:0] cfg_wdata_i,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  req_t       in_data_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output rsp_t       out_data_o
);

  localparam int unsigned QW = $clog2(QUEUE_DEPTH);
  localparam int unsigned SW = $clog2(VOICE_COUNT + 1);
  localparam int unsigned VW = (VOICE_COUNT > 1) ? $clog2(VOICE_COUNT) : 1;
  localparam logic [SW-1:0] NoSlot = SW'(VOICE_COUNT);
  localparam logic [QW-1:0] QLast  = QW'(QUEUE_DEPTH - 1);

  // Voice entry memory: prev, next, priority, stop-armed
  typedef struct packed {
    logic [SW-1:0] prev;
    logic [SW-1:0] next;
    logic [7:0]    pri;
    logic          stop;
  } voice_t;

  ring_entry_t ring_mem [QUEUE_DEPTH];
  voice_t      voice_mem [VOICE_COUNT];

  logic [8:0]    limit_q;
  logic [QW-1:0] wp_q, wp_d, rp_q, rp_d;
  logic          pv_q, pv_d;
  ring_entry_t   pend_q, pend_d;
  logic [SW-1:0] head_q, head_d, tail_q, tail_d;
  logic [SW-1:0] fcnt_q, fcnt_d;
  logic [SW-1:0] fstk_q [VOICE_COUNT];
  logic [VOICE_COUNT-1:0] act_q;
  state_e        st_q, st_d;
  req_t          req_q;
  rsp_t          rsp_q, rsp_d;
  logic          ov_q, ov_d;
  logic [SW-1:0] cur_q, cur_d, slot_q, slot_d, aux_q, aux_d;
  logic [SW-1:0] steps_q, steps_d;
  voice_t        cv_q, cv_d;

  // Memory port controls
  logic          ring_we;
  logic [QW-1:0] ring_waddr;
  ring_entry_t   ring_rdata;
  logic          v_we;
  logic [VW-1:0] v_waddr, v_raddr;
  voice_t        v_wdata, v_rdata;
  logic          fs_push;
  logic [SW-1:0] fs_val;
  logic          act_set, act_clr;

  logic          vol_ok;
  logic [7:0]    vol_c;
  logic [QW-1:0] wp_nx;

  assign in_ready_o  = (st_q == SIdle) && !ov_q;
  assign out_valid_o = ov_q;
  assign out_data_o  = rsp_q;

  // Request ring memory
  always_ff @(posedge clk_i) begin
    if (ring_we) ring_mem[ring_waddr] <= ring_entry_t'{in_data_i.sound_id, vol_c,
                                                       in_data_i.req_priority};
    ring_rdata <= ring_mem[rp_q];
  end

  // Voice entry memory
  always_ff @(posedge clk_i) begin
    if (v_we) voice_mem[v_waddr] <= v_wdata;
    v_rdata <= voice_mem[v_raddr];
  end

  assign wp_nx  = (wp_q == QLast) ? '0 : wp_q + 1'b1;
  assign vol_ok = !in_data_i.req_volume[15] && (in_data_i.req_volume != '0);
  assign vol_c  = (in_data_i.req_volume[14:8] != '0) ? VolumeMax : in_data_i.req_volume[7:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= IdLimitReset;
      wp_q <= '0; rp_q <= '0; pv_q <= 1'b0;
      head_q <= NoSlot; tail_q <= NoSlot; fcnt_q <= NoSlot;
      for (int i = 0; i < VOICE_COUNT; i++) fstk_q[i] <= SW'(i);
      act_q <= '0;
      st_q <= SIdle; ov_q <= 1'b0;
    end else begin
      if (cfg_we_i) limit_q <= cfg_wdata_i;
      wp_q <= wp_d; rp_q <= rp_d; pv_q <= pv_d;
      head_q <= head_d; tail_q <= tail_d; fcnt_q <= fcnt_d;
      if (fs_push) fstk_q[fcnt_q[VW-1:0]] <= fs_val;
      if (act_set) act_q[slot_q[VW-1:0]] <= 1'b1;
      if (act_clr) act_q[req_q.done_slot[VW-1:0]] <= 1'b0;
      st_q <= st_d; ov_q <= ov_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) req_q <= in_data_i;
    pend_q <= pend_d; rsp_q <= rsp_d;
    cur_q <= cur_d; slot_q <= slot_d; aux_q <= aux_d; steps_q <= steps_d; cv_q <= cv_d;
  end

  // Sequencer
  always_comb begin
    logic [SW-1:0] s;
    logic [7:0]    id;
    st_d = st_q; ov_d = ov_q; rsp_d = rsp_q;
    wp_d = wp_q; rp_d = rp_q; pv_d = pv_q; pend_d = pend_q;
    head_d = head_q; tail_d = tail_q; fcnt_d = fcnt_q;
    cur_d = cur_q; slot_d = slot_q; aux_d = aux_q; steps_d = steps_q; cv_d = cv_q;
    ring_we = 1'b0; ring_waddr = wp_q;
    v_we = 1'b0; v_waddr = '0; v_wdata = cv_q; v_raddr = cur_q[VW-1:0];
    fs_push = 1'b0; fs_val = req_q.done_slot[SW-1:0];
    act_set = 1'b0; act_clr = 1'b0;
    s = fstk_q[fcnt_q[VW-1:0] - 1'b1];
    id = '0;
    if (ov_q && out_ready_i) ov_d = 1'b0;

    case (st_q)
      SIdle: begin
        if (in_valid_i && in_ready_o) begin
          rsp_d = '0;
          case (op_e'(in_data_i.operation))
            OpEnqueue: begin
              if (vol_ok) begin
                if (wp_nx == rp_q) rsp_d.status = StFull;
                else begin
                  ring_we = 1'b1;
                  wp_d = wp_nx;
                end
              end
              ov_d = 1'b1;
            end
            OpTick: st_d = (!pv_q && rp_q != wp_q) ? SRingRd : STailRd;
            OpDone: begin
              if (in_data_i.done_slot < 4'(VOICE_COUNT) &&
                  act_q[in_data_i.done_slot[VW-1:0]]) begin
                cur_d = in_data_i.done_slot[SW-1:0];
                st_d = SUnlinkRd;
              end else ov_d = 1'b1;
            end
            default: begin
              wp_d = '0; rp_d = '0; pv_d = 1'b0;
              ov_d = 1'b1;
            end
          endcase
        end
      end
      SRingRd: begin
        // ring_rdata holds entry at rp_q now
        pend_d = ring_rdata; pv_d = 1'b1;
        rp_d = (rp_q == QLast) ? '0 : rp_q + 1'b1;
        st_d = STailRd;
      end
      STailRd: begin
        if (!pv_q) begin
          ov_d = 1'b1; st_d = SIdle;
        end else if (fcnt_q == '0) begin
          if (tail_q == NoSlot) begin
            pv_d = 1'b0; rsp_d.status = StDropped; ov_d = 1'b1; st_d = SIdle;
          end else begin
            cur_d = tail_q; st_d = STailChk;
          end
        end else begin
          if (s >= NoSlot) s = '0;
          slot_d = s; fcnt_d = fcnt_q - 1'b1;
          cur_d = head_q; steps_d = '0;
          st_d = SWalkRd;
        end
      end
      STailChk: begin
        v_raddr = cur_q[VW-1:0];
        st_d = SRingLoad;
      end
      SRingLoad: begin
        // v_rdata is the tail voice
        if (pend_q.pri < v_rdata.pri) begin
          pv_d = 1'b0; rsp_d.status = StDropped;
        end else begin
          if (v_rdata.stop) begin
            v_we = 1'b1; v_waddr = cur_q[VW-1:0];
            v_wdata = v_rdata; v_wdata.stop = 1'b0;
            rsp_d.command = CmdStop; rsp_d.voice_slot = 4'(cur_q);
          end
          rsp_d.status = StPending;
        end
        ov_d = 1'b1; st_d = SIdle;
      end
      SWalkRd: begin
        if (cur_q == NoSlot || steps_q == NoSlot) begin
          // append at tail
          aux_d = NoSlot; st_d = SLinkA;
          cv_d.prev = tail_q; cv_d.next = NoSlot;
        end else begin
          v_raddr = cur_q[VW-1:0];
          st_d = SWalkChk;
        end
      end
      SWalkChk: begin
        if (pend_q.pri >= v_rdata.pri) begin
          cv_d.prev = v_rdata.prev; cv_d.next = cur_q;
          aux_d = cur_q;
          // cur gets prev = slot
          v_we = 1'b1; v_waddr = cur_q[VW-1:0];
          v_wdata = v_rdata; v_wdata.prev = slot_q;
          st_d = SLinkA;
        end else begin
          cur_d = v_rdata.next; steps_d = steps_q + 1'b1;
          st_d = SWalkRd;
        end
      end
      SLinkA: begin
        // write new voice entry; read predecessor
        v_we = 1'b1; v_waddr = slot_q[VW-1:0];
        v_wdata = cv_q; v_wdata.pri = pend_q.pri; v_wdata.stop = 1'b1;
        act_set = 1'b1;
        if (aux_q == NoSlot) tail_d = slot_q;
        if (cv_q.prev == NoSlot) begin
          head_d = slot_q; st_d = SOut;
        end else begin
          v_raddr = cv_q.prev[VW-1:0]; st_d = SLinkB;
        end
      end
      SLinkB: begin
        v_we = 1'b1; v_waddr = cv_q.prev[VW-1:0];
        v_wdata = v_rdata; v_wdata.next = slot_q;
        st_d = SOut;
      end
      SOut: begin
        id = (9'(pend_q.id) >= limit_q) ? 8'd0 : pend_q.id;
        pv_d = 1'b0;
        rsp_d.command = CmdStart; rsp_d.voice_slot = 4'(slot_q);
        rsp_d.out_sound_id = id; rsp_d.out_volume = pend_q.vol;
        rsp_d.out_pan = CenterPan; rsp_d.out_priority = pend_q.pri;
        rsp_d.status = StOk;
        ov_d = 1'b1; st_d = SIdle;
      end
      SUnlinkRd: begin
        v_raddr = cur_q[VW-1:0]; st_d = SUnlinkA;
      end
      SUnlinkA: begin
        cv_d = v_rdata;
        act_clr = 1'b1;
        if (fcnt_q < NoSlot) begin
          fs_push = 1'b1; fcnt_d = fcnt_q + 1'b1;
        end
        if (v_rdata.next < NoSlot) begin
          v_raddr = v_rdata.next[VW-1:0];
        end else tail_d = v_rdata.prev;
        if (v_rdata.prev < NoSlot) begin
          v_raddr = v_rdata.prev[VW-1:0];
          st_d = SUnlinkB;
          aux_d = '0;
        end else begin
          head_d = v_rdata.next;
          if (v_rdata.next < NoSlot) begin
            st_d = SUnlinkB; aux_d = NoSlot;
          end else begin
            ov_d = 1'b1; st_d = SIdle;
          end
        end
      end
      SUnlinkB: begin
        // aux_q == 0: v_rdata is prev entry; else next entry
        v_we = 1'b1;
        if (aux_q == '0) begin
          v_waddr = cv_q.prev[VW-1:0]; v_wdata = v_rdata; v_wdata.next = cv_q.next;
          if (cv_q.next < NoSlot) begin
            aux_d = NoSlot; st_d = SUnlinkRd; cur_d = cv_q.next;
            cv_d = cv_q;
            st_d = SLinkB;
          end else begin
            ov_d = 1'b1; st_d = SIdle;
          end
        end else begin
          v_waddr = cv_q.next[VW-1:0]; v_wdata = v_rdata; v_wdata.prev = cv_q.prev;
          ov_d = 1'b1; st_d = SIdle;
        end
        if (aux_q == '0 && cv_q.next < NoSlot) begin
          // issue read of next entry, finish in SUnlinkB with aux set
          v_raddr = cv_q.next[VW-1:0];
          st_d = SUnlinkB;
        end
      end
      default: st_d = SIdle;
    endcase
  end

endmodule

/* rtl/srq_checker.sv */
// Checker: port-level properties of the allocator, bound to the top level.
module srq_checker
  import srq_pkg::*;
(
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid_i,
  input logic in_ready_o,
  input logic out_valid_o,
  input logic out_ready_i,
  input rsp_t out_data_o
);

  // A started voice always carries center pan
  a_pan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.command == CmdStart |-> out_data_o.out_pan == CenterPan)
    else $error("start without center pan");

  // Non-start results carry zero pan
  a_nopan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.command != CmdStart |-> out_data_o.out_pan == '0)
    else $error("pan on non-start result");

  // Stop only comes with pending status
  a_stop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.command == CmdStop |-> out_data_o.status == StPending)
    else $error("stop without pending status");

  // No new transaction accepted while a result is waiting
  a_one: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |-> !in_ready_o)
    else $error("input ready while result stalled");

endmodule

bind sound_request_queue_voice_allocator srq_checker u_srq_checker (
  .clk_i(clk_i), .rst_ni(rst_ni), .in_valid_i(in_valid_i), .in_ready_o(in_ready_o),
  .out_valid_o(out_valid_o), .out_ready_i(out_ready_i), .out_data_o(out_data_o)
);

/* dv/voice_allocator_checker.sv */
`timescale 1ns / 1ps
// Checker: watches both channels and the config port, predicts each response and compares.
module voice_allocator_checker
  import srq_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic [8:0] cfg_wdata_i,
  input  logic       in_valid_i,
  input  logic       in_ready_o,
  input  req_t       in_data_i,
  input  logic       out_valid_o,
  input  logic       out_ready_i,
  input  rsp_t       out_data_o,
  output int         fail_count,
  output int         outstanding,
  output int         start_count,
  output int         stop_count,
  output int         drop_count,
  output int         full_count
);

  localparam int Depth  = 64;
  localparam int Voices = 13;
  localparam int NoSlot = Voices;

  // Shadow copy of the allocator state
  logic [7:0] ring_id  [Depth];
  logic [7:0] ring_vol [Depth];
  logic [7:0] ring_pri [Depth];
  int         wr_ptr, rd_ptr;
  bit         pend_valid;
  logic [7:0] pend_id, pend_vol, pend_pri;
  int         link_prev [Voices];
  int         link_next [Voices];
  logic [7:0] voice_pri [Voices];
  bit         voice_stop [Voices];
  bit         voice_busy [Voices];
  int         head, tail;
  int         free_stk [Voices];
  int         free_cnt;
  logic [8:0] id_limit;

  rsp_t expected_rsps[$];

  function automatic int ring_inc(int p);
    return (p + 1 >= Depth) ? 0 : p + 1;
  endfunction

  // Apply one request to the shadow state and return the response it should produce
  function automatic rsp_t allocate_voice(req_t r);
    rsp_t       o;
    int         s, cur, p, n, steps, nxt;
    bit         placed;
    logic [7:0] id;
    o = '0;
    case (op_e'(r.operation))
      OpEnqueue: begin
        if (r.req_volume > 0) begin
          nxt = ring_inc(wr_ptr);
          if (nxt == rd_ptr) begin
            o.status = StFull;
          end else begin
            ring_id[wr_ptr]  = r.sound_id;
            ring_vol[wr_ptr] = (r.req_volume >= 256) ? VolumeMax : r.req_volume[7:0];
            ring_pri[wr_ptr] = r.req_priority;
            wr_ptr = nxt;
          end
        end
      end
      OpTick: begin
        if (!pend_valid && rd_ptr != wr_ptr) begin
          pend_id    = ring_id[rd_ptr];
          pend_vol   = ring_vol[rd_ptr];
          pend_pri   = ring_pri[rd_ptr];
          pend_valid = 1;
          rd_ptr     = ring_inc(rd_ptr);
        end
        if (pend_valid) begin
          if (free_cnt == 0) begin
            if (tail >= NoSlot || pend_pri < voice_pri[tail]) begin
              pend_valid = 0;
              o.status = StDropped;
            end else begin
              // steal: one stop per tail voice, then keep waiting
              if (voice_stop[tail]) begin
                voice_stop[tail] = 0;
                o.command    = CmdStop;
                o.voice_slot = tail[3:0];
              end
              o.status = StPending;
            end
          end else begin
            free_cnt--;
            s = free_stk[free_cnt];
            id = (pend_id >= id_limit) ? 8'd0 : pend_id;
            voice_pri[s]  = pend_pri;
            voice_stop[s] = 1;
            voice_busy[s] = 1;
            // sorted insert, new voice ahead of equal priority
            cur = head;
            steps = 0;
            placed = 0;
            while (!placed && cur < NoSlot && steps < Voices) begin
              if (voice_pri[s] >= voice_pri[cur]) begin
                p = link_prev[cur];
                link_next[s] = cur;
                link_prev[s] = p;
                if (p < NoSlot) link_next[p] = s; else head = s;
                link_prev[cur] = s;
                placed = 1;
              end else begin
                cur = link_next[cur];
                steps++;
              end
            end
            if (!placed) begin
              link_next[s] = NoSlot;
              link_prev[s] = tail;
              if (tail < NoSlot) link_next[tail] = s; else head = s;
              tail = s;
            end
            pend_valid = 0;
            o.command      = CmdStart;
            o.voice_slot   = s[3:0];
            o.out_sound_id = id;
            o.out_volume   = pend_vol;
            o.out_pan      = CenterPan;
            o.out_priority = pend_pri;
          end
        end
      end
      OpDone: begin
        s = r.done_slot;
        if (s < NoSlot && voice_busy[s]) begin
          p = link_prev[s];
          n = link_next[s];
          if (p < NoSlot) link_next[p] = n; else head = n;
          if (n < NoSlot) link_prev[n] = p; else tail = p;
          voice_busy[s] = 0;
          if (free_cnt < Voices) begin
            free_stk[free_cnt] = s;
            free_cnt++;
          end
        end
      end
      default: begin
        wr_ptr = 0;
        rd_ptr = 0;
        pend_valid = 0;
      end
    endcase
    return o;
  endfunction

  function automatic void check_field(string name, int exp_v, int act_v);
    if (exp_v != act_v) begin
      $display("%0t: %s expected %0d actual %0d", $time, name, exp_v, act_v);
      fail_count++;
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    rsp_t e;
    if (!rst_ni) begin
      for (int i = 0; i < Voices; i++) begin
        link_prev[i] = NoSlot;
        link_next[i] = NoSlot;
        voice_pri[i] = 0;
        voice_stop[i] = 0;
        voice_busy[i] = 0;
        free_stk[i] = i;
      end
      wr_ptr = 0;
      rd_ptr = 0;
      pend_valid = 0;
      head = NoSlot;
      tail = NoSlot;
      free_cnt = Voices;
      id_limit = IdLimitReset;
      expected_rsps.delete();
      fail_count = 0;
      start_count = 0;
      stop_count = 0;
      drop_count = 0;
      full_count = 0;
    end else begin
      // response side first: it belongs to an earlier transaction
      if (out_valid_o && out_ready_i) begin
        if (expected_rsps.size() == 0) begin
          $display("%0t: unexpected response, expected none, actual %h", $time, out_data_o);
          fail_count++;
        end else begin
          e = expected_rsps.pop_front();
          check_field("command", e.command, out_data_o.command);
          check_field("voice_slot", e.voice_slot, out_data_o.voice_slot);
          check_field("out_sound_id", e.out_sound_id, out_data_o.out_sound_id);
          check_field("out_volume", e.out_volume, out_data_o.out_volume);
          check_field("out_pan", e.out_pan, out_data_o.out_pan);
          check_field("out_priority", e.out_priority, out_data_o.out_priority);
          check_field("status", e.status, out_data_o.status);
        end
      end
      if (cfg_we_i) id_limit = cfg_wdata_i;
      if (in_valid_i && in_ready_o) begin
        e = allocate_voice(in_data_i);
        if (e.command == CmdStart) start_count++;
        if (e.command == CmdStop) stop_count++;
        if (e.status == StDropped) drop_count++;
        if (e.status == StFull) full_count++;
        expected_rsps.push_back(e);
      end
    end
    outstanding = expected_rsps.size();
  end

endmodule

/* dv/sound_request_queue_voice_allocator_test.sv */
`timescale 1ns / 1ps
// Testbench top: stimulus, flow control and verdict for the voice allocator.
module sound_request_queue_voice_allocator_test;
  import srq_pkg::*;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       cfg_we_i = 1'b0;
  logic [8:0] cfg_wdata_i = '0;
  logic       in_valid_i = 1'b0;
  logic       in_ready_o;
  req_t       in_data_i = '0;
  logic       out_valid_o;
  logic       out_ready_i = 1'b0;
  rsp_t       out_data_o;

  int fail_count, outstanding, start_count, stop_count, drop_count, full_count;
  int burst_left = 0;
  int sent_count = 0;
  bit long_hold_req = 0;

  sound_request_queue_voice_allocator u_top (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_wdata_i,
    .in_valid_i, .in_ready_o, .in_data_i,
    .out_valid_o, .out_ready_i, .out_data_o
  );

  voice_allocator_checker u_checker (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_wdata_i,
    .in_valid_i, .in_ready_o, .in_data_i,
    .out_valid_o, .out_ready_i, .out_data_o,
    .fail_count, .outstanding, .start_count, .stop_count, .drop_count, .full_count
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Offer one transaction; bursts of random length separated by random gaps
  task automatic send(input req_t r);
    if (burst_left == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
      burst_left = $urandom_range(1, 20);
    end
    burst_left--;
    in_valid_i <= 1'b1;
    in_data_i  <= r;
    do @(posedge clk_i); while (!in_ready_o);
    sent_count++;
  endtask

  function automatic req_t make_req(op_e op, logic [7:0] id, logic signed [15:0] vol,
                                    logic [7:0] pri, logic [3:0] slot);
    req_t r;
    r.operation = op;
    r.sound_id = id;
    r.req_volume = vol;
    r.req_priority = pri;
    r.done_slot = slot;
    return r;
  endfunction

  function automatic logic signed [15:0] rand_volume();
    case ($urandom_range(0, 3))
      0: return 16'($urandom);
      1: return 16'($urandom_range(1, 255));
      2: return 16'($urandom_range(256, 32767));
      default: return -16'sd1 * 16'($urandom_range(0, 32768));
    endcase
  endfunction

  function automatic logic [7:0] rand_pri();
    // narrow range now and then so ties are common
    return ($urandom_range(0, 1)) ? 8'($urandom) : 8'($urandom_range(0, 3));
  endfunction

  function automatic req_t rand_req();
    int pick;
    op_e op;
    logic [3:0] slot;
    pick = $urandom_range(0, 99);
    op = (pick < 45) ? OpEnqueue : (pick < 80) ? OpTick : (pick < 97) ? OpDone : OpFlush;
    slot = ($urandom_range(0, 9) < 7) ? 4'($urandom_range(0, 12)) : 4'($urandom);
    return make_req(op, 8'($urandom), rand_volume(), rand_pri(), slot);
  endfunction

  task automatic wait_idle();
    if (burst_left != 0 || in_valid_i) in_valid_i <= 1'b0;
    burst_left = 0;
    @(posedge clk_i);
    while (outstanding != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
  endtask

  task automatic write_limit(input logic [8:0] v);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  // Random phase: mostly single ops, plus ring floods and voice fill sequences
  task automatic run_random(input int n);
    int done_items;
    int pick;
    done_items = 0;
    while (done_items < n) begin
      pick = $urandom_range(0, 99);
      if (pick < 6) begin
        repeat (66) send(make_req(OpEnqueue, 8'($urandom), 16'($urandom_range(1, 400)),
                                  rand_pri(), 4'($urandom)));
        done_items += 66;
      end else if (pick < 14) begin
        repeat (14) begin
          send(make_req(OpEnqueue, 8'($urandom), rand_volume() | 16'sd1, rand_pri(),
                        4'($urandom)));
          send(make_req(OpTick, 8'($urandom), 16'($urandom), 8'($urandom), 4'($urandom)));
        end
        done_items += 28;
      end else begin
        send(rand_req());
        done_items++;
      end
    end
  endtask

  // Receiver: ready pattern switches among always, random and sparse modes, with one long hold-off on request
  always @(posedge clk_i) begin
    static int cyc = 0;
    static int hold_cnt = 0;
    static int mode = 0;
    cyc++;
    if (cyc % 64 == 0) mode = $urandom_range(0, 2);
    if (long_hold_req) begin
      long_hold_req = 0;
      hold_cnt = 300;
    end
    if (hold_cnt > 0) begin
      hold_cnt--;
      out_ready_i <= 1'b0;
    end else begin
      case (mode)
        0: out_ready_i <= 1'b1;
        1: out_ready_i <= 1'($urandom_range(0, 1));
        default: out_ready_i <= ($urandom_range(0, 3) == 0);
      endcase
    end
  end

  // Stimulus and verdict
  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: volume edges, id limit edges, empty tick, bad done slots, flush
    send(make_req(OpEnqueue, 8'd5, 16'sd0, 8'd1, 4'd0));
    send(make_req(OpEnqueue, 8'd6, -16'sd32768, 8'd1, 4'd0));
    send(make_req(OpEnqueue, 8'd7, -16'sd1, 8'd1, 4'd0));
    send(make_req(OpEnqueue, 8'd255, 16'sd32767, 8'd255, 4'd15));
    send(make_req(OpEnqueue, 8'd111, 16'sd255, 8'd0, 4'd0));
    send(make_req(OpEnqueue, 8'd112, 16'sd1, 8'd255, 4'd0));
    send(make_req(OpEnqueue, 8'd0, 16'sd256, 8'd7, 4'd0));
    repeat (5) send(make_req(OpTick, 8'd0, 16'sd0, 8'd0, 4'd0));
    send(make_req(OpDone, 8'd0, 16'sd0, 8'd0, 4'd15));
    send(make_req(OpDone, 8'd0, 16'sd0, 8'd0, 4'd13));
    send(make_req(OpDone, 8'd0, 16'sd0, 8'd0, 4'd12));
    send(make_req(OpDone, 8'd0, 16'sd0, 8'd0, 4'd12));
    send(make_req(OpEnqueue, 8'd9, 16'sd100, 8'd3, 4'd0));
    send(make_req(OpFlush, 8'd0, 16'sd0, 8'd0, 4'd0));
    send(make_req(OpTick, 8'd0, 16'sd0, 8'd0, 4'd0));
    send(make_req(OpDone, 8'd0, 16'sd0, 8'd0, 4'd11));

    // random phases under several id limits
    run_random(480);
    wait_idle();
    write_limit(9'd1);
    long_hold_req = 1;
    run_random(480);
    wait_idle();
    write_limit(9'd256);
    run_random(480);
    wait_idle();
    write_limit(9'd112);
    run_random(240);
    wait_idle();
    write_limit(9'($urandom_range(1, 256)));
    run_random(240);
    wait_idle();

    $display("Sent %0d transactions over five id limits, including 1 and 256.", sent_count);
    $display("Starts %0d, stops %0d, drops %0d, full-ring rejects %0d.",
             start_count, stop_count, drop_count, full_count);
    if (fail_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #4ms;
    $display("Mismatches found");
    $finish;
  end

endmodule
